[hdl/lpfr_pkg.sv]
// Package for the length-prefixed frame receiver.
// Holds shared constants, result kinds and the structs passed between the
// front end, the job queue and the back end. No dependencies.
`default_nettype none

package lpfr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 7;
  localparam int ADDR_W      = IDX_W + 1;  // two banks of the payload store
  localparam int LEN_LIMIT   = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
  localparam logic [7:0] START_MARKER_RESET = 8'd170;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_BAD_START = 2'd1,
    KIND_OVERSIZE  = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    F_HUNT,
    F_LEN,
    F_PAYLOAD
  } fstate_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_LOAD
  } bstate_e;

  // One unit of work for the back end: a single result or a payload burst.
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data;
    logic [LEN_W-1:0]  length;
    logic              bank;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_clr_t;

endpackage

`default_nettype wire

[hdl/lpfr_front.sv]
// Front end of the frame receiver: parses incoming bytes, writes payload
// bytes into the store banks and pushes jobs into the job queue. Uses lpfr_pkg.
`default_nettype none

module lpfr_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [7:0]                rx_byte_i,
  input  wire logic                      cfg_valid_i,
  input  wire logic [7:0]                cfg_data_i,
  output logic                           push_o,
  output lpfr_pkg::job_t                 job_o,
  input  wire logic                      push_ready_i,
  output lpfr_pkg::wr_t                  wr_o,
  input  wire lpfr_pkg::bank_clr_t       clr_i
);

  lpfr_pkg::fstate_e                state_q, state_d;
  logic [lpfr_pkg::IDX_W-1:0]       idx_q, idx_d;
  logic [lpfr_pkg::LEN_W-1:0]       size_q, size_d;
  logic                             wbank_q, wbank_d;
  logic [1:0]                       busy_q, busy_d;
  logic [7:0]                       marker_q, marker_d;
  logic                             accept;
  logic                             set_busy;

  assign in_stall_o = !push_ready_i || (state_q == lpfr_pkg::F_PAYLOAD && busy_q[wbank_q]);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    size_d   = size_q;
    wbank_d  = wbank_q;
    marker_d = cfg_valid_i ? cfg_data_i : marker_q;
    push_o   = 1'b0;
    job_o    = '0;
    wr_o     = '0;
    set_busy = 1'b0;
    if (accept) begin
      unique case (state_q)
        lpfr_pkg::F_HUNT: begin
          if (rx_byte_i != marker_q) begin
            push_o      = 1'b1;
            job_o.kind  = lpfr_pkg::KIND_BAD_START;
            job_o.data  = rx_byte_i;
          end else begin
            state_d = lpfr_pkg::F_LEN;
          end
        end
        lpfr_pkg::F_LEN: begin
          if ({1'b0, rx_byte_i} > 9'(lpfr_pkg::LEN_LIMIT)) begin
            push_o     = 1'b1;
            job_o.kind = lpfr_pkg::KIND_OVERSIZE;
            job_o.data = rx_byte_i;
            state_d    = lpfr_pkg::F_HUNT;
          end else if (rx_byte_i == 8'd0) begin
            push_o     = 1'b1;
            job_o.kind = lpfr_pkg::KIND_EMPTY;
            size_d     = '0;
            state_d    = lpfr_pkg::F_HUNT;
          end else begin
            size_d  = rx_byte_i[lpfr_pkg::LEN_W-1:0];
            idx_d   = '0;
            state_d = lpfr_pkg::F_PAYLOAD;
          end
        end
        lpfr_pkg::F_PAYLOAD: begin
          wr_o.en   = 1'b1;
          wr_o.addr = {wbank_q, idx_q};
          wr_o.data = rx_byte_i;
          if (({1'b0, idx_q} + 1'b1) == size_q) begin
            // Hand the filled bank to the back end and switch banks.
            push_o       = 1'b1;
            job_o.kind   = lpfr_pkg::KIND_PAYLOAD;
            job_o.length = size_q;
            job_o.bank   = wbank_q;
            set_busy     = 1'b1;
            wbank_d      = ~wbank_q;
            state_d      = lpfr_pkg::F_HUNT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: state_d = lpfr_pkg::F_HUNT;
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (clr_i.en) busy_d[clr_i.bank] = 1'b0;
    if (set_busy) busy_d[wbank_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lpfr_pkg::F_HUNT;
      idx_q    <= '0;
      size_q   <= '0;
      wbank_q  <= 1'b0;
      busy_q   <= '0;
      marker_q <= lpfr_pkg::START_MARKER_RESET;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      size_q   <= size_d;
      wbank_q  <= wbank_d;
      busy_q   <= busy_d;
      marker_q <= marker_d;
    end
  end

endmodule

`default_nettype wire

[hdl/lpfr_jobq.sv]
// Two-entry job queue between the front end and the back end.
// Uses lpfr_pkg for the job struct.
`default_nettype none

module lpfr_jobq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lpfr_pkg::job_t  job_i,
  output logic                 push_ready_o,
  input  wire logic            pop_i,
  output lpfr_pkg::job_t       job_o,
  output logic                 job_valid_o
);

  lpfr_pkg::job_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign job_valid_o  = (count_q != 2'd0);
  assign job_o        = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && job_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= job_i;
  end

endmodule

`default_nettype wire

[hdl/lpfr_back.sv]
// Back end of the frame receiver: holds the two-bank payload store, takes
// jobs from the queue and drives the registered result channel. Uses lpfr_pkg.
`default_nettype none

module lpfr_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lpfr_pkg::wr_t                 wr_i,
  input  wire lpfr_pkg::job_t                job_i,
  input  wire logic                          job_valid_i,
  output logic                               pop_o,
  output lpfr_pkg::bank_clr_t                clr_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         kind_o,
  output logic [7:0]                         data_o,
  output logic [lpfr_pkg::IDX_W-1:0]         payload_index_o,
  output logic [lpfr_pkg::LEN_W-1:0]         frame_length_o,
  output logic                               last_o
);

  localparam int MemDepth = 2 * lpfr_pkg::STORE_DEPTH;

  logic [7:0] mem [MemDepth];
  logic [7:0] rd_data_q;
  logic       rd_en;

  lpfr_pkg::bstate_e              state_q, state_d;
  logic [lpfr_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [lpfr_pkg::LEN_W-1:0]     len_q, len_d;
  logic                           bank_q, bank_d;

  logic                           out_valid_q;
  logic [1:0]                     kind_q;
  logic [7:0]                     data_q;
  logic [lpfr_pkg::IDX_W-1:0]     index_q;
  logic [lpfr_pkg::LEN_W-1:0]     length_q;
  logic                           last_q;

  logic                           out_free;
  logic                           load;
  logic [1:0]                     kind_n;
  logic [7:0]                     data_n;
  logic [lpfr_pkg::IDX_W-1:0]     index_n;
  logic [lpfr_pkg::LEN_W-1:0]     length_n;
  logic                           last_n;
  logic                           burst_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign burst_last = (({1'b0, idx_q} + 1'b1) == len_q);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    len_d    = len_q;
    bank_d   = bank_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    clr_o    = '0;
    load     = 1'b0;
    kind_n   = lpfr_pkg::KIND_PAYLOAD;
    data_n   = rd_data_q;
    index_n  = idx_q;
    length_n = len_q;
    last_n   = burst_last;
    unique case (state_q)
      lpfr_pkg::B_IDLE: begin
        if (job_valid_i) begin
          if (job_i.kind == lpfr_pkg::KIND_PAYLOAD) begin
            pop_o   = 1'b1;
            idx_d   = '0;
            len_d   = job_i.length;
            bank_d  = job_i.bank;
            state_d = lpfr_pkg::B_READ;
          end else if (out_free) begin
            // Single result: error or empty frame.
            pop_o    = 1'b1;
            load     = 1'b1;
            kind_n   = job_i.kind;
            data_n   = job_i.data;
            index_n  = '0;
            length_n = '0;
            last_n   = 1'b1;
          end
        end
      end
      lpfr_pkg::B_READ: begin
        rd_en   = 1'b1;
        state_d = lpfr_pkg::B_LOAD;
      end
      lpfr_pkg::B_LOAD: begin
        if (out_free) begin
          load = 1'b1;
          if (burst_last) begin
            // Byte is in the output register; release the bank.
            clr_o.en   = 1'b1;
            clr_o.bank = bank_q;
            state_d    = lpfr_pkg::B_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = lpfr_pkg::B_READ;
          end
        end
      end
      default: state_d = lpfr_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.data;
    if (rd_en) rd_data_q <= mem[{bank_q, idx_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpfr_pkg::B_IDLE;
      idx_q       <= '0;
      len_q       <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      bank_q  <= bank_d;
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_n;
      data_q   <= data_n;
      index_q  <= index_n;
      length_q <= length_n;
      last_q   <= last_n;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_o          = data_q;
  assign payload_index_o = index_q;
  assign frame_length_o  = length_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

[hdl/length_prefixed_frame_receiver.sv]
// Top level of the length-prefixed frame receiver.
// Instantiates lpfr_front, lpfr_jobq and lpfr_back; uses lpfr_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / rx_byte_i) takes one received
//   byte per transaction. A frame is the start marker, a length byte and that
//   many payload bytes. The start marker is set through cfg_valid_i /
//   cfg_data_i (cfg_ready_o is always high); it resets to 170.
//   Output channel (out_valid_o / out_stall_i) carries one result per
//   transaction: kind, data, payload_index, frame_length and last.
//   A bad start, oversize or empty-frame result passes through the job queue
//   into the output register after its byte is accepted. The first result of a
//   completed frame follows its last byte through job pop, store read and
//   output load; each further result of the burst takes a store read, then an
//   output load.
//   Throughput: one input byte per cycle. The input stalls while the two-entry
//   job queue is full, or when a payload byte would go to a store bank whose
//   previous frame is still draining (two banks alternate between frames).
//   Reset clears all control state and returns the start marker to 170; there
//   is no store clearing pass. An output stall holds the result and backs up
//   the queue.
`default_nettype none

module length_prefixed_frame_receiver (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 rx_byte_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [7:0]                 cfg_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      kind_o,
  output logic [7:0]                      data_o,
  output logic [lpfr_pkg::IDX_W-1:0]      payload_index_o,
  output logic [lpfr_pkg::LEN_W-1:0]      frame_length_o,
  output logic                            last_o
);

  logic                 push;
  logic                 push_ready;
  lpfr_pkg::job_t       push_job;
  lpfr_pkg::job_t       head_job;
  logic                 head_valid;
  logic                 pop;
  lpfr_pkg::wr_t        wr;
  lpfr_pkg::bank_clr_t  clr;

  assign cfg_ready_o = 1'b1;

  lpfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push),
    .job_o        (push_job),
    .push_ready_i (push_ready),
    .wr_o         (wr),
    .clr_i        (clr)
  );

  lpfr_jobq u_jobq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (push_job),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .job_o        (head_job),
    .job_valid_o  (head_valid)
  );

  lpfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .job_i           (head_job),
    .job_valid_i     (head_valid),
    .pop_o           (pop),
    .clr_o           (clr),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .data_o          (data_o),
    .payload_index_o (payload_index_o),
    .frame_length_o  (frame_length_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
